// File: design/hds_pkg.sv
`timescale 1ns / 1ps

package hds_pkg;

    typedef logic signed [15:0] cell_t;
    typedef logic [15:0]        ratio_t;
    typedef logic [1:0]         op_t;
    typedef logic [7:0]         idx_t;
    typedef logic [1:0]         reg_idx_t;
    typedef logic [15:0]        cfg_data_t;

    localparam op_t OP_LOAD = 2'd0;
    localparam op_t OP_STEP = 2'd1;
    localparam op_t OP_READ = 2'd2;

    localparam reg_idx_t REG_RATIO = 2'd0;
    localparam reg_idx_t REG_LEFT  = 2'd1;
    localparam reg_idx_t REG_RIGHT = 2'd2;

    localparam ratio_t RATIO_RESET = 16'd24576;
    localparam cell_t  LEFT_RESET  = 16'sd0;
    localparam cell_t  RIGHT_RESET = 16'sd8192;

    localparam cell_t CELL_MAX = 16'sh7fff;
    localparam cell_t CELL_MIN = 16'sh8000;

    typedef struct packed {
        logic accept;
        logic clr_wr;
        logic ld_wr;
        logic rd_item;
        logic st_p0;
        logic st_p1;
        logic st_mul;
        logic st_wb;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic cell_last;
        logic idx_ok;
        op_t  op;
    } status_t;

endpackage

// File: design/hds_item_if.sv
`timescale 1ns / 1ps

interface hds_item_if;
    import hds_pkg::*;

    logic  valid;
    logic  ready;
    op_t   op;
    idx_t  cell_index;
    cell_t cell_value;

    modport source (output valid, output op, output cell_index, output cell_value,
                    input ready);
    modport sink (input valid, input op, input cell_index, input cell_value,
                  output ready);
endinterface

// File: design/hds_result_if.sv
`timescale 1ns / 1ps

interface hds_result_if;
    import hds_pkg::*;

    logic  valid;
    logic  ready;
    cell_t read_value;
    logic  index_error;

    modport source (output valid, output read_value, output index_error, input ready);
    modport sink (input valid, input read_value, input index_error, output ready);
endinterface

// File: design/hds_ctrl.sv
`timescale 1ns / 1ps

module hds_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    output logic             result_valid,
    input  logic             result_ready,
    input  hds_pkg::status_t status,
    output hds_pkg::cmd_t    cmd
);
    import hds_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_P0     = 3'd3;
    localparam logic [2:0] S_P1     = 3'd4;
    localparam logic [2:0] S_MUL    = 3'd5;
    localparam logic [2:0] S_WB     = 3'd6;
    localparam logic [2:0] S_FIN    = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign result_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !result_ready;
        cmd            = '0;
        item_ready     = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (status.op)
                    OP_LOAD:
                    begin
                        cmd.ld_wr  = status.idx_ok;
                        state_next = S_FIN;
                    end
                    OP_STEP:
                    begin
                        state_next = S_P0;
                    end
                    OP_READ:
                    begin
                        cmd.rd_item = status.idx_ok;
                        state_next  = S_FIN;
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_P0:
            begin
                cmd.st_p0  = 1'b1;
                state_next = S_P1;
            end
            S_P1:
            begin
                cmd.st_p1  = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.st_mul = 1'b1;
                state_next = S_WB;
            end
            S_WB:
            begin
                cmd.st_wb  = 1'b1;
                state_next = status.cell_last ? S_FIN : S_MUL;
            end
            S_FIN:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTH
    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clr_wr, cmd.ld_wr, cmd.st_p0, cmd.st_p1, cmd.st_wb}))
        else $error("more than one memory write source");

    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_ready) |=> out_valid_reg)
        else $error("pending result dropped");

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> (state_reg == S_DECODE))
        else $error("accepted transaction not decoded");

    a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB && status.cell_last) |=> (state_reg == S_FIN))
        else $error("sweep did not finish after last cell");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || result_ready))
        else $error("result register overwritten");
`endif

endmodule

// File: design/hds_datapath.sv
`timescale 1ns / 1ps

module hds_datapath #(
    parameter int CELLS = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  hds_pkg::reg_idx_t cfg_index,
    input  hds_pkg::cfg_data_t cfg_data,
    input  hds_pkg::op_t      in_op,
    input  hds_pkg::idx_t     in_index,
    input  hds_pkg::cell_t    in_value,
    input  hds_pkg::cmd_t     cmd,
    output hds_pkg::status_t  status,
    output hds_pkg::cell_t    read_value,
    output logic              index_error
);
    import hds_pkg::*;

    localparam int AW = $clog2(CELLS);
    localparam int CW = $clog2(CELLS + 1);
    localparam int IW = (CW > 8) ? CW : 8;

    ratio_t ratio_reg;
    cell_t  left_bnd_reg;
    cell_t  right_bnd_reg;

    op_t    op_reg;
    idx_t   idx_reg;
    cell_t  val_reg;

    logic [AW-1:0] count_reg;
    logic [AW-1:0] count_next;

    cell_t left_reg;
    cell_t left_next;
    cell_t mid_reg;
    cell_t mid_next;
    cell_t hold_reg;
    cell_t hold_next;
    logic signed [34:0] prod_reg;
    logic signed [34:0] prod_next;

    cell_t out_value_reg;
    cell_t out_value_next;
    logic  out_err_reg;
    logic  out_err_next;

    cell_t         mem_arr [CELLS];
    cell_t         rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    cell_t         mem_wd;
    logic          mem_re;
    logic [AW-1:0] mem_ra;

    logic               idx_ok;
    logic [AW-1:0]      item_addr;
    cell_t              right_val;
    logic signed [16:0] ratio_s;
    logic signed [17:0] lap;
    logic signed [18:0] delta;
    logic signed [19:0] sum;
    cell_t              new_cell;

    assign idx_ok    = IW'(idx_reg) < IW'(CELLS);
    assign item_addr = AW'(idx_reg);

    assign status.clear_last = (count_reg == AW'(CELLS - 1));
    assign status.cell_last  = (count_reg == AW'(CELLS - 2));
    assign status.idx_ok     = idx_ok;
    assign status.op         = op_reg;

    assign right_val = status.cell_last ? right_bnd_reg : rd_data_reg;
    assign ratio_s   = $signed({1'b0, ratio_reg});
    assign lap       = 18'(right_val) - 18'(mid_reg) - 18'(mid_reg) + 18'(left_reg);
    assign prod_next = 35'(ratio_s) * 35'(lap);
    assign delta     = prod_reg[34:16];
    assign sum       = 20'(mid_reg) + 20'(delta);

    always_comb
    begin
        if (sum > 20'(CELL_MAX))
        begin
            new_cell = CELL_MAX;
        end
        else if (sum < 20'(CELL_MIN))
        begin
            new_cell = CELL_MIN;
        end
        else
        begin
            new_cell = sum[15:0];
        end
    end

    always_comb
    begin
        mem_we     = 1'b0;
        mem_wa     = count_reg;
        mem_wd     = '0;
        mem_re     = 1'b0;
        mem_ra     = item_addr;
        count_next = count_reg;
        left_next  = left_reg;
        mid_next   = mid_reg;
        hold_next  = hold_reg;
        if (cmd.clr_wr)
        begin
            mem_we     = 1'b1;
            count_next = count_reg + AW'(1);
        end
        if (cmd.ld_wr)
        begin
            mem_we = 1'b1;
            mem_wa = item_addr;
            mem_wd = val_reg;
        end
        if (cmd.rd_item)
        begin
            mem_re = 1'b1;
        end
        if (cmd.st_p0)
        begin
            mem_we     = 1'b1;
            mem_wa     = '0;
            mem_wd     = left_bnd_reg;
            mem_re     = 1'b1;
            mem_ra     = AW'(1);
            left_next  = left_bnd_reg;
            count_next = AW'(1);
        end
        if (cmd.st_p1)
        begin
            mem_we   = 1'b1;
            mem_wa   = AW'(CELLS - 1);
            mem_wd   = right_bnd_reg;
            mem_re   = 1'b1;
            mem_ra   = AW'(2);
            mid_next = rd_data_reg;
        end
        if (cmd.st_mul)
        begin
            hold_next = right_val;
        end
        if (cmd.st_wb)
        begin
            mem_we     = 1'b1;
            mem_wa     = count_reg;
            mem_wd     = new_cell;
            mem_re     = !status.cell_last;
            mem_ra     = count_reg + AW'(2);
            left_next  = new_cell;
            mid_next   = hold_reg;
            count_next = count_reg + AW'(1);
        end
    end

    always_comb
    begin
        out_value_next = (op_reg == OP_READ && idx_ok) ? rd_data_reg : '0;
        out_err_next   = (op_reg inside {OP_LOAD, OP_READ}) && !idx_ok;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_arr[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem_arr[mem_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg     <= RATIO_RESET;
            left_bnd_reg  <= LEFT_RESET;
            right_bnd_reg <= RIGHT_RESET;
            count_reg     <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_RATIO: ratio_reg     <= cfg_data;
                    REG_LEFT:  left_bnd_reg  <= cfg_data;
                    REG_RIGHT: right_bnd_reg <= cfg_data;
                    default:   ratio_reg     <= ratio_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= in_op;
            idx_reg <= in_index;
            val_reg <= in_value;
        end
        if (cmd.out_load)
        begin
            out_value_reg <= out_value_next;
            out_err_reg   <= out_err_next;
        end
        left_reg <= left_next;
        mid_reg  <= mid_next;
        hold_reg <= hold_next;
        if (cmd.st_mul)
        begin
            prod_reg <= prod_next;
        end
    end

    assign read_value  = out_value_reg;
    assign index_error = out_err_reg;

endmodule

// File: design/heat_diffusion_stencil_1d.sv
`timescale 1ns / 1ps

// row of CELLS Q2.14 temperatures with an explicit 1-d heat diffusion step
// item channel: op 0 loads cell_index with cell_value, op 1 runs one time
//   step, op 2 reads cell_index; one transaction on the result channel per item
// result: read_value for a valid read, index_error for a load or read with cell_index >= CELLS
// config: plain write port, taken at any edge with cfg_write high, no read-back
// load, read and unused op: the item passes the decode and finish states,
//   and the next item is taken only once its result is in the output register
// time step: each cell passes a multiply state and then a state for the add,
//   saturate and write-back, since the next cell needs the new value of this
//   one
// the row sits in a single-port-write, single-port-read memory
// reset: configuration takes its defaults and a clearing pass over all CELLS
//   cells zeroes the row; item.ready stays low until it ends
// a stalled receiver: the finished result waits in the output register and
//   one more item is accepted and worked on; that item then waits for the
//   register to empty before the next is taken
module heat_diffusion_stencil_1d #(
    parameter int CELLS = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    hds_item_if.sink           item,
    hds_result_if.source       result,
    input  logic               cfg_write,
    input  hds_pkg::reg_idx_t  cfg_index,
    input  hds_pkg::cfg_data_t cfg_data
);
    import hds_pkg::*;

    cmd_t    cmd;
    status_t status;

    hds_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd)
    );

    hds_datapath #(
        .CELLS (CELLS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_op       (item.op),
        .in_index    (item.cell_index),
        .in_value    (item.cell_value),
        .cmd         (cmd),
        .status      (status),
        .read_value  (result.read_value),
        .index_error (result.index_error)
    );

endmodule
